FILE: design/arkt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arkt_pkg: shared types and constants of the address range key table
// Request and response beats, table entry layout, command and status codes.
// ----------------------------------------------------------------------------
package arkt_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int ADDR_W       = 48;
	localparam int SIZE_W       = 32;
	localparam int KEY_W        = 32;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int SUM_W        = 39;
	localparam int STAT_W       = 3;
	localparam int CMD_W        = 2;
	localparam int FIDX_W       = 6;
	localparam int ECNT_W       = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 3'd0,
		ST_MISS  = 3'd1,
		ST_FULL  = 3'd2,
		ST_ZERO  = 3'd3,
		ST_ORDER = 3'd4
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] seg_start;
		logic [SIZE_W-1:0] seg_size;
		logic [KEY_W-1:0]  seg_key;
		logic [ADDR_W-1:0] lookup_addr;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  found_key;
		logic [FIDX_W-1:0] found_index;
		logic [ECNT_W-1:0] entry_count;
		logic [SUM_W-1:0]  total_bytes;
	} rsp_t;

	// one table row as held in memory
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] len;
		logic [KEY_W-1:0]  key;
	} entry_t;

	// midpoint of a search window, lo < hi <= MAX_SEGMENTS
	function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
			input logic [CNT_W-1:0] hi);
		logic [CNT_W:0] sum;
		sum = {1'b0, lo} + {1'b0, hi};
		return sum[IDX_W:1];
	endfunction

endpackage

FILE: design/arkt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arkt_ram: segment entry memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module arkt_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [arkt_pkg::IDX_W-1:0] waddr,
	input  arkt_pkg::entry_t          wdata,
	input  logic                      re,
	input  logic [arkt_pkg::IDX_W-1:0] raddr,
	output arkt_pkg::entry_t          rdata
);

	arkt_pkg::entry_t mem [arkt_pkg::MAX_SEGMENTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/address_range_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_key_table: sorted segment table with binary search lookup
// Appends segments in ascending start order and finds the segment that
// covers an address by an upper-bound search over the entry memory.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload  handshake
//   req      in         req_t    req_valid / req_stall
//   rsp      out        rsp_t    rsp_valid / rsp_stall
//
// Append, clear and the unused code pass from accept through S_DONE to the output
// register. A lookup runs its probes in S_PROBE, then goes through S_CHECK and S_DONE:
// one probe per cycle through the single memory read port.
// One item at a time; req_stall is high while an item is in work.
// A held result waits in the output register while the next beat is taken.
// Reset empties the table at once; the entry memory needs no clearing.
// ----------------------------------------------------------------------------
module address_range_key_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  arkt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output arkt_pkg::rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_CHECK,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [arkt_pkg::CNT_W-1:0]    count_q;
	logic [arkt_pkg::SUM_W-1:0]    sum_q;
	logic [arkt_pkg::ADDR_W:0]     last_end_q;
	logic [arkt_pkg::CNT_W-1:0]    lo_q;
	logic [arkt_pkg::CNT_W-1:0]    hi_q;
	logic [arkt_pkg::IDX_W-1:0]    mid_q;
	logic [arkt_pkg::ADDR_W-1:0]   addr_q;
	logic [arkt_pkg::ADDR_W-1:0]   cand_start_q;
	logic [arkt_pkg::SIZE_W-1:0]   cand_len_q;
	logic [arkt_pkg::KEY_W-1:0]    cand_key_q;
	arkt_pkg::rsp_t                res_q;
	arkt_pkg::rsp_t                rsp_q;
	logic                          rsp_valid_q;

	logic                          req_fire;
	logic                          ram_we;
	logic                          ram_re;
	logic [arkt_pkg::IDX_W-1:0]    ram_raddr;
	arkt_pkg::entry_t              ram_wdata;
	arkt_pkg::entry_t              ram_rdata;
	arkt_pkg::status_t             app_status;
	logic [arkt_pkg::ADDR_W:0]     app_end;
	logic                          probe_le;
	logic [arkt_pkg::CNT_W-1:0]    lo_n;
	logic [arkt_pkg::CNT_W-1:0]    hi_n;
	logic [arkt_pkg::ADDR_W-1:0]   diff;
	logic                          hit;
	logic                          out_free;
	arkt_pkg::rsp_t                res_idle;
	arkt_pkg::rsp_t                res_chk;

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// append checks, in priority order: full, zero length, out of order
	assign app_end = {1'b0, req.seg_start}
		+ {{(arkt_pkg::ADDR_W + 1 - arkt_pkg::SIZE_W){1'b0}}, req.seg_size};
	always_comb begin
		if (count_q >= arkt_pkg::CNT_W'(arkt_pkg::MAX_SEGMENTS)) begin
			app_status = arkt_pkg::ST_FULL;
		end else if (req.seg_size == '0) begin
			app_status = arkt_pkg::ST_ZERO;
		end else if ({1'b0, req.seg_start} < last_end_q) begin
			app_status = arkt_pkg::ST_ORDER;
		end else begin
			app_status = arkt_pkg::ST_OK;
		end
	end

	// one search step on the entry read last cycle
	assign probe_le = (ram_rdata.start <= addr_q);
	assign lo_n     = probe_le ? arkt_pkg::CNT_W'({1'b0, mid_q} + 1'b1) : lo_q;
	assign hi_n     = probe_le ? hi_q : {1'b0, mid_q};

	// range check on the last entry whose start is not above the address
	assign diff = addr_q - cand_start_q;
	assign hit  = (lo_q != '0)
		&& (diff < {{(arkt_pkg::ADDR_W - arkt_pkg::SIZE_W){1'b0}}, cand_len_q});

	// result of a command that completes at accept
	always_comb begin
		res_idle             = '0;
		res_idle.status      = arkt_pkg::ST_OK;
		res_idle.entry_count = count_q;
		res_idle.total_bytes = sum_q;
		case (arkt_pkg::cmd_t'(req.cmd))
			arkt_pkg::CMD_APPEND: begin
				res_idle.status = app_status;
				if (app_status == arkt_pkg::ST_OK) begin
					res_idle.entry_count = count_q + 1'b1;
					res_idle.total_bytes = sum_q + arkt_pkg::SUM_W'(req.seg_size);
				end
			end
			arkt_pkg::CMD_CLEAR: begin
				res_idle.entry_count = '0;
				res_idle.total_bytes = '0;
			end
			default: begin
				res_idle.status = arkt_pkg::ST_OK;
			end
		endcase
	end

	// lookup verdict after the search
	always_comb begin
		res_chk             = '0;
		res_chk.entry_count = count_q;
		res_chk.total_bytes = sum_q;
		if (hit) begin
			res_chk.status      = arkt_pkg::ST_OK;
			res_chk.found_key   = cand_key_q;
			res_chk.found_index = arkt_pkg::FIDX_W'(lo_q - 1'b1);
		end else begin
			res_chk.status      = arkt_pkg::ST_MISS;
		end
	end

	// memory port control
	assign ram_wdata = '{start: req.seg_start, len: req.seg_size, key: req.seg_key};
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = arkt_pkg::mid_of('0, count_q);
		case (state_q)
			S_IDLE: begin
				ram_we = req_fire && (arkt_pkg::cmd_t'(req.cmd) == arkt_pkg::CMD_APPEND)
					&& (app_status == arkt_pkg::ST_OK);
				ram_re = req_fire && (arkt_pkg::cmd_t'(req.cmd) == arkt_pkg::CMD_LOOKUP)
					&& (count_q != '0);
			end
			S_PROBE: begin
				ram_re    = (lo_n < hi_n);
				ram_raddr = arkt_pkg::mid_of(lo_n, hi_n);
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	arkt_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[arkt_pkg::IDX_W-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, table state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			sum_q        <= '0;
			last_end_q   <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			addr_q       <= '0;
			cand_start_q <= '0;
			cand_len_q   <= '0;
			cand_key_q   <= '0;
			res_q        <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// load a new beat, or drop the held beat once taken
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						res_q <= res_idle;
						if (arkt_pkg::cmd_t'(req.cmd) == arkt_pkg::CMD_LOOKUP) begin
							state_q <= (count_q != '0) ? S_PROBE : S_CHECK;
						end else begin
							state_q <= S_DONE;
						end
						case (arkt_pkg::cmd_t'(req.cmd))
							arkt_pkg::CMD_APPEND: begin
								if (app_status == arkt_pkg::ST_OK) begin
									count_q    <= count_q + 1'b1;
									sum_q      <= sum_q + arkt_pkg::SUM_W'(req.seg_size);
									last_end_q <= app_end;
								end
							end
							arkt_pkg::CMD_LOOKUP: begin
								addr_q <= req.lookup_addr;
								lo_q   <= '0;
								hi_q   <= count_q;
								mid_q  <= arkt_pkg::mid_of('0, count_q);
							end
							arkt_pkg::CMD_CLEAR: begin
								count_q    <= '0;
								sum_q      <= '0;
								last_end_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_PROBE: begin
					// advance the window; keep the entry that moved lo
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					mid_q <= arkt_pkg::mid_of(lo_n, hi_n);
					if (probe_le) begin
						cand_start_q <= ram_rdata.start;
						cand_len_q   <= ram_rdata.len;
						cand_key_q   <= ram_rdata.key;
					end
					if (!(lo_n < hi_n)) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					res_q   <= res_chk;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hand the result to the output register when it frees up
					if (out_free) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
